// ===== rtl/core/seq_region_reorder_buffer_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the sequence/region reorder buffer
// Implication and next-cycle checks clocked on clock, idle during reset.
// ----------------------------------------------------------------------------
`ifndef SEQ_REGION_REORDER_BUFFER_UNIT_ASSERT_SVH
`define SEQ_REGION_REORDER_BUFFER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SRRB_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SRRB_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/srrb_pkg.sv =====
// ----------------------------------------------------------------------------
// Sequence/region reorder buffer package
// Sizes, status codes and register indexes shared by the buffer.
// ----------------------------------------------------------------------------
package srrb_pkg;

   localparam int WINDOW_SLOTS = 32;
   localparam int MAX_REGIONS  = 16;
   localparam int PAYLOAD_BITS = 16;

   localparam int SLOT_BITS   = $clog2(WINDOW_SLOTS);
   localparam int SEQ_BITS    = 32;
   localparam int REGION_BITS = 5;
   localparam int TAG_BITS    = 16;
   localparam int STATUS_BITS = 2;
   localparam int OFFSET_BITS = SLOT_BITS + REGION_BITS;

   localparam int REQ_DATA_BITS = ((SEQ_BITS + REGION_BITS + TAG_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_BITS = ((TAG_BITS + SEQ_BITS + REGION_BITS + 7) / 8) * 8;

   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 32;

   typedef logic [SEQ_BITS-1:0]     seq_type;
   typedef logic [REGION_BITS-1:0]  region_type;
   typedef logic [PAYLOAD_BITS-1:0] payload_type;
   typedef logic [SLOT_BITS-1:0]    slot_type;
   typedef logic [STATUS_BITS-1:0]  status_type;

   localparam status_type ST_RELEASED = 2'd0;
   localparam status_type ST_STALE    = 2'd1;
   localparam status_type ST_BEYOND   = 2'd2;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_REGION_COUNT   = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FIRST_SEQUENCE = 2'd1;

   localparam region_type REGION_COUNT_RESET = 5'd1;
   localparam seq_type    FIRST_SEQ_RESET    = 32'd1;
   localparam region_type REGION_FIRST       = 5'd1;
   localparam region_type REGION_MAX         = REGION_BITS'(MAX_REGIONS);

endpackage

// ===== rtl/core/seq_region_reorder_buffer_unit.sv =====
// ----------------------------------------------------------------------------
// Sequence/region reorder buffer
// Stores tagged requests in a window of slots and releases them in key order.
//
//   Channel  Direction  Handshake             Contents
//   req      in         req_tvalid/tready     seq_number, region, payload_tag
//   rsp      out        rsp_tvalid/tready     payload, seq, region, status, last
//   csr      in         csr_valid/csr_ready   register index and write data
//
// A request passes the check and placement states, then every released entry
// passes the slot memory read and then the response register.
// A rejected request passes the check and reject states to the response
// register, and placement too when only the offset puts it beyond the window.
// The release loop, one slot memory read port and the response register set
// the rate; a stalled response holds the sequencer in place.
// Reset empties every slot at once; writing first_sequence does the same, and
// register writes are taken only while the sequencer is idle.
// ----------------------------------------------------------------------------
`include "seq_region_reorder_buffer_unit_assert.svh"

module seq_region_reorder_buffer_unit
   import srrb_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // seq_number [31:0], region [36:32], payload_tag [52:37], zeros above
   input  logic [REQ_DATA_BITS-1:0]  req_tdata,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // out_payload [15:0], out_seq [47:16], out_region [52:48], zeros above
   output logic [RSP_DATA_BITS-1:0]  rsp_tdata,
   // status [1:0]
   output logic [STATUS_BITS-1:0]    rsp_tuser,
   output logic                      rsp_tlast,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_CHECK = 3'd1;
   localparam logic [2:0] S_PLACE = 3'd2;
   localparam logic [2:0] S_REJ   = 3'd3;
   localparam logic [2:0] S_RD    = 3'd4;
   localparam logic [2:0] S_OUT   = 3'd5;

   logic [2:0]               state_ff, state_in;
   logic [WINDOW_SLOTS-1:0]  slot_valid_ff;
   payload_type              slot_mem [WINDOW_SLOTS];
   payload_type              rd_data_ff;
   region_type               region_count_ff;
   seq_type                  exp_seq_ff;
   region_type               exp_region_ff;
   slot_type                 head_ff;
   seq_type                  in_seq_ff;
   region_type               in_region_ff;
   payload_type              in_payload_ff;
   slot_type                 dist_ff;
   status_type               rej_status_ff;
   seq_type                  key_seq_ff;
   region_type               key_region_ff;
   logic                     key_last_ff;
   logic                     rsp_tvalid_ff;
   logic [RSP_DATA_BITS-1:0] rsp_tdata_ff;
   status_type               rsp_tuser_ff;
   logic                     rsp_tlast_ff;

   region_type               count;
   region_type               new_count;
   seq_type                  diff;
   logic                     region_bad;
   logic                     stale;
   logic [OFFSET_BITS-1:0]   offset;
   slot_type                 wr_slot;
   slot_type                 head_next;
   logic                     rsp_free;
   logic                     mem_we;
   logic                     mem_re;
   logic                     req_fire;
   logic                     csr_fire;
   logic                     region_wrap;
   logic                     exp_region_ok;
   logic                     rsp_reject;

   always_comb begin
      priority if (region_count_ff == '0) begin
         count = REGION_FIRST;
      end else if (region_count_ff > REGION_MAX) begin
         count = REGION_MAX;
      end else begin
         count = region_count_ff;
      end
      priority if (csr_data[REGION_BITS-1:0] == '0) begin
         new_count = REGION_FIRST;
      end else if (csr_data[REGION_BITS-1:0] > REGION_MAX) begin
         new_count = REGION_MAX;
      end else begin
         new_count = csr_data[REGION_BITS-1:0];
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_fire   = csr_valid && csr_ready;
   assign rsp_free   = !rsp_tvalid_ff || rsp_tready;

   assign diff       = in_seq_ff - exp_seq_ff;
   assign region_bad = (in_region_ff == '0) || (in_region_ff > count);
   assign stale      = (in_seq_ff < exp_seq_ff) ||
                       ((in_seq_ff == exp_seq_ff) && (in_region_ff < exp_region_ff));
   assign offset     = OFFSET_BITS'(dist_ff) * OFFSET_BITS'(count)
                       + OFFSET_BITS'(in_region_ff) - OFFSET_BITS'(exp_region_ff);
   assign wr_slot    = head_ff + offset[SLOT_BITS-1:0];
   assign head_next  = head_ff + SLOT_BITS'(1);
   assign region_wrap = (exp_region_ff >= count);
   assign mem_we     = (state_ff == S_PLACE) && (offset < OFFSET_BITS'(WINDOW_SLOTS));
   assign mem_re     = (state_ff == S_RD) && slot_valid_ff[head_ff];

   assign exp_region_ok = (exp_region_ff >= REGION_FIRST) && (exp_region_ff <= count);
   assign rsp_reject    = rsp_tvalid_ff && (rsp_tuser_ff != ST_RELEASED);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) state_in = S_CHECK;
         end
         S_CHECK: begin
            if (region_bad || stale || (diff[SEQ_BITS-1:SLOT_BITS] != '0)) begin
               state_in = S_REJ;
            end else begin
               state_in = S_PLACE;
            end
         end
         S_PLACE: begin
            state_in = mem_we ? S_RD : S_REJ;
         end
         S_REJ: begin
            if (rsp_free) state_in = S_IDLE;
         end
         S_RD: begin
            state_in = mem_re ? S_OUT : S_IDLE;
         end
         S_OUT: begin
            if (rsp_free) state_in = key_last_ff ? S_IDLE : S_RD;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) slot_mem[wr_slot] <= in_payload_ff;
      if (mem_re) rd_data_ff <= slot_mem[head_ff];
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_seq_ff     <= req_tdata[SEQ_BITS-1:0];
         in_region_ff  <= req_tdata[SEQ_BITS +: REGION_BITS];
         in_payload_ff <= PAYLOAD_BITS'(req_tdata[SEQ_BITS+REGION_BITS +: TAG_BITS]);
      end
      if (state_ff == S_CHECK) begin
         dist_ff       <= diff[SLOT_BITS-1:0];
         rej_status_ff <= (stale && !region_bad) ? ST_STALE : ST_BEYOND;
      end
      if (state_ff == S_PLACE) begin
         rej_status_ff <= ST_BEYOND;
      end
      if (mem_re) begin
         key_seq_ff    <= exp_seq_ff;
         key_region_ff <= exp_region_ff;
         key_last_ff   <= !slot_valid_ff[head_next];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         slot_valid_ff   <= '0;
         region_count_ff <= REGION_COUNT_RESET;
         exp_seq_ff      <= FIRST_SEQ_RESET;
         exp_region_ff   <= REGION_FIRST;
         head_ff         <= '0;
         rsp_tvalid_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (mem_we) slot_valid_ff[wr_slot] <= 1'b1;
         if (mem_re) begin
            slot_valid_ff[head_ff] <= 1'b0;
            head_ff <= head_next;
            if (region_wrap) begin
               exp_region_ff <= REGION_FIRST;
               exp_seq_ff    <= exp_seq_ff + SEQ_BITS'(1);
            end else begin
               exp_region_ff <= exp_region_ff + REGION_BITS'(1);
            end
         end
         if (rsp_free) begin
            rsp_tvalid_ff <= (state_ff == S_REJ) || (state_ff == S_OUT);
            if (state_ff == S_REJ) begin
               rsp_tdata_ff  <= RSP_DATA_BITS'({in_region_ff, in_seq_ff,
                                                TAG_BITS'(in_payload_ff)});
               rsp_tuser_ff  <= rej_status_ff;
               rsp_tlast_ff  <= 1'b1;
            end else if (state_ff == S_OUT) begin
               rsp_tdata_ff  <= RSP_DATA_BITS'({key_region_ff, key_seq_ff,
                                                TAG_BITS'(rd_data_ff)});
               rsp_tuser_ff  <= ST_RELEASED;
               rsp_tlast_ff  <= key_last_ff;
            end
         end
         if (csr_fire) begin
            unique case (csr_index)
               CSR_REGION_COUNT: begin
                  region_count_ff <= csr_data[REGION_BITS-1:0];
                  if (exp_region_ff > new_count) exp_region_ff <= new_count;
               end
               CSR_FIRST_SEQUENCE: begin
                  exp_seq_ff    <= csr_data[SEQ_BITS-1:0];
                  exp_region_ff <= REGION_FIRST;
                  head_ff       <= '0;
                  slot_valid_ff <= '0;
               end
               default: begin
               end
            endcase
         end
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;
   assign rsp_tlast  = rsp_tlast_ff;

   `SRRB_ASSERT_NEXT(a_accept_to_check, req_fire, state_ff == S_CHECK, "request not checked")
   `SRRB_ASSERT_SAME(a_region_in_range, 1'b1, exp_region_ok, "expected region out of range")
   `SRRB_ASSERT_NEXT(a_release_step, mem_re, state_ff == S_OUT, "release did not reach output")
   `SRRB_ASSERT_NEXT(a_release_clear, mem_re, !slot_valid_ff[$past(head_ff)], "released slot kept")
   `SRRB_ASSERT_SAME(a_reject_is_last, rsp_reject, rsp_tlast_ff, "rejection without last marker")

endmodule
